// ===== rtl/acbp_pkg.sv =====
// Shared types for the ack-clocked burst pacer: event codes and the queued item.
// No dependencies; the front end, queue, back end and top level refer to it by scoped names.
package acbp_pkg;

	typedef enum logic [2:0] {
		OP_INIT     = 3'd0,
		OP_RECONF   = 3'd1,
		OP_SCHED    = 3'd2,
		OP_SENT     = 3'd3,
		OP_NOT_SENT = 3'd4,
		OP_ACKED    = 3'd5,
		OP_QUERY    = 3'd6
	} op_t;

	typedef struct packed {
		op_t         op;
		logic        stream_pkt;
		logic [15:0] new_max;
		logic [63:0] acked_bytes;
		logic [15:0] bytes_per_token;
		logic        size_zero;
	} item_t;

	typedef struct packed {
		logic        can_send;
		logic        can_probe;
		logic [15:0] token_count;
		logic [15:0] bucket_max;
		logic [31:0] sent_count;
		logic        blocked;
		logic        refilled;
		logic        resumed;
	} res_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

// ===== rtl/acbp_if.sv =====
// Valid/ready channel interfaces for the pacer: event requests and result responses.
// Stand-alone; no package needed.
interface acbp_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  op;
	logic        stream_pkt;
	logic [15:0] new_max;
	logic [63:0] acked_bytes;
	logic [15:0] bytes_per_token;

	modport source(output valid, op, stream_pkt, new_max, acked_bytes, bytes_per_token,
		input ready);
	modport sink(input valid, op, stream_pkt, new_max, acked_bytes, bytes_per_token,
		output ready);
endinterface

interface acbp_rsp_if;
	logic        valid;
	logic        ready;
	logic        can_send;
	logic        can_probe;
	logic [15:0] token_count;
	logic [15:0] bucket_max;
	logic [31:0] sent_count;
	logic        blocked;
	logic        refilled;
	logic        resumed;

	modport source(output valid, can_send, can_probe, token_count, bucket_max,
		sent_count, blocked, refilled, resumed, input ready);
	modport sink(input valid, can_send, can_probe, token_count, bucket_max,
		sent_count, blocked, refilled, resumed, output ready);
endinterface

// ===== rtl/acbp_front.sv =====
// Front end: accepts request transactions, decodes the event code and registers the item.
// Depends on acbp_pkg and acbp_req_if; feeds acbp_queue.
module acbp_front (
	input  logic                clk,
	input  logic                arst_n,
	acbp_req_if.sink            req,
	input  acbp_pkg::q_stat_t   q_stat,
	output logic                push,
	output acbp_pkg::item_t     push_item
);

	logic            v_s1;
	acbp_pkg::item_t item_s1;
	acbp_pkg::item_t dec;
	logic            take;

	always_comb begin
		dec.stream_pkt      = req.stream_pkt;
		dec.new_max         = req.new_max;
		dec.acked_bytes     = req.acked_bytes;
		dec.bytes_per_token = req.bytes_per_token;
		dec.size_zero       = (req.bytes_per_token == 16'd0);
		// the spare code behaves as a query
		if (req.op > acbp_pkg::OP_QUERY) begin
			dec.op = acbp_pkg::OP_QUERY;
		end else begin
			dec.op = acbp_pkg::op_t'(req.op);
		end
	end

	assign push      = v_s1 && !q_stat.full;
	assign req.ready = !v_s1 || !q_stat.full;
	assign take      = req.valid && req.ready;
	assign push_item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (take) begin
			v_s1 <= 1'b1;
		end else if (push) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= dec;
		end
	end

endmodule

// ===== rtl/acbp_queue.sv =====
// Two-entry queue between front and back end of the pacer.
// Depends on acbp_pkg for the item and status types.
module acbp_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  acbp_pkg::item_t   push_item,
	input  logic              pop,
	output acbp_pkg::item_t   pop_item,
	output acbp_pkg::q_stat_t q_stat
);

	acbp_pkg::item_t mem [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      cnt_q;

	assign q_stat.full  = (cnt_q == 2'd2);
	assign q_stat.empty = (cnt_q == 2'd0);
	assign pop_item     = mem[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_item;
		end
	end

endmodule

// ===== rtl/acbp_back.sv =====
// Back end: holds the bucket state, runs each event and the serial ack divider,
// and drives the result register. Depends on acbp_pkg and acbp_rsp_if.
module acbp_back #(
	parameter int TOKEN_BITS = 16,
	parameter int SENT_BITS  = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  acbp_pkg::q_stat_t   q_stat,
	input  acbp_pkg::item_t     pop_item,
	output logic                pop,
	acbp_rsp_if.source          rsp
);

	localparam int DIV_STEPS = 64;
	localparam int CNT_BITS  = $clog2(DIV_STEPS);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_DIV,
		ST_PREP,
		ST_COMMIT
	} state_t;

	state_t                 state_q;
	acbp_pkg::item_t        item_q;
	logic [TOKEN_BITS-1:0]  tok_q;
	logic [TOKEN_BITS-1:0]  cap_q;
	logic [SENT_BITS-1:0]   sent_q;
	logic                   bp_q;
	logic [63:0]            base_q;

	logic [63:0]            n_q;
	logic [15:0]            rem_q;
	logic [CNT_BITS-1:0]    cnt_q;
	logic                   sat_q;
	logic [31:0]            qs_q;
	logic [63:0]            prod_q;

	logic                   out_valid_q;
	acbp_pkg::res_t         res_q;

	logic [31:0]            nmax32;
	logic [TOKEN_BITS-1:0]  nmax;
	logic [64:0]            diff;
	logic                   ack_go;
	logic                   out_free;
	logic                   commit;
	logic [16:0]            trial;
	logic                   trial_ge;
	logic [16:0]            trial_sub;
	logic [TOKEN_BITS-1:0]  head;
	logic [TOKEN_BITS-1:0]  tok_n;
	logic [TOKEN_BITS-1:0]  cap_n;
	logic [SENT_BITS-1:0]   sent_n;
	logic                   bp_n;
	logic [63:0]            base_n;
	logic                   refilled;
	logic                   resumed;
	logic [31:0]            rep_tok32;
	logic [31:0]            cap32;
	logic [31:0]            rep_sent32;
	acbp_pkg::res_t         res_n;

	assign nmax32   = {16'd0, item_q.new_max};
	assign nmax     = nmax32[TOKEN_BITS-1:0];
	assign diff     = {1'b0, item_q.acked_bytes} - {1'b0, base_q};
	assign ack_go   = (item_q.op == acbp_pkg::OP_ACKED) && !item_q.size_zero && !diff[64];
	assign out_free = !out_valid_q || rsp.ready;
	assign commit   = out_free && ((state_q == ST_EXEC && !ack_go) || state_q == ST_COMMIT);
	assign pop      = (state_q == ST_IDLE) && !q_stat.empty;

	// restoring division step, one quotient bit a cycle
	assign trial     = {rem_q, n_q[63]};
	assign trial_ge  = trial >= {1'b0, item_q.bytes_per_token};
	assign trial_sub = trial - {1'b0, item_q.bytes_per_token};
	assign head      = cap_q - tok_q;

	always_comb begin
		tok_n    = tok_q;
		cap_n    = cap_q;
		sent_n   = sent_q;
		bp_n     = bp_q;
		base_n   = base_q;
		refilled = 1'b0;
		resumed  = 1'b0;
		case (item_q.op)
			acbp_pkg::OP_INIT: begin
				cap_n  = nmax;
				tok_n  = nmax;
				sent_n = '0;
				bp_n   = 1'b0;
				base_n = item_q.acked_bytes;
			end
			acbp_pkg::OP_RECONF: begin
				cap_n = nmax;
				if (tok_q > nmax) begin
					tok_n = nmax;
				end
			end
			acbp_pkg::OP_SCHED: begin
				if (item_q.stream_pkt && tok_q != '0) begin
					tok_n = tok_q - TOKEN_BITS'(1);
				end
			end
			acbp_pkg::OP_SENT: begin
				if (item_q.stream_pkt && !(&sent_q)) begin
					sent_n = sent_q + SENT_BITS'(1);
				end
			end
			acbp_pkg::OP_NOT_SENT: begin
				if (!bp_q) begin
					tok_n  = '0;
					sent_n = '0;
					bp_n   = 1'b1;
				end
			end
			acbp_pkg::OP_ACKED: begin
				if (state_q == ST_COMMIT && qs_q != 32'd0) begin
					base_n = sat_q ? (base_q + prod_q)
						: (item_q.acked_bytes - {48'd0, rem_q});
					if (tok_q == '0) begin
						sent_n = '0;
					end
					if (tok_q >= cap_q || qs_q >= 32'(head)) begin
						tok_n = cap_q;
					end else begin
						tok_n = tok_q + qs_q[TOKEN_BITS-1:0];
					end
					refilled = 1'b1;
					bp_n     = 1'b0;
					resumed  = bp_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		// not_sent reports the counters as they stood before it
		if (item_q.op == acbp_pkg::OP_NOT_SENT) begin
			rep_tok32     = 32'(tok_q);
			rep_sent32    = 32'(sent_q);
			res_n.blocked = bp_q;
		end else begin
			rep_tok32     = 32'(tok_n);
			rep_sent32    = 32'(sent_n);
			res_n.blocked = bp_n;
		end
		cap32             = 32'(cap_n);
		res_n.can_send    = (tok_n != '0);
		res_n.can_probe   = (tok_n > TOKEN_BITS'(1));
		res_n.token_count = rep_tok32[15:0];
		res_n.bucket_max  = cap32[15:0];
		res_n.sent_count  = rep_sent32;
		res_n.refilled    = refilled;
		res_n.resumed     = resumed;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			tok_q       <= '0;
			cap_q       <= '0;
			sent_q      <= '0;
			bp_q        <= 1'b0;
			base_q      <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (commit) begin
				tok_q       <= tok_n;
				cap_q       <= cap_n;
				sent_q      <= sent_n;
				bp_q        <= bp_n;
				base_q      <= base_n;
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (ack_go) begin
						cnt_q   <= '0;
						state_q <= ST_DIV;
					end else if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q + CNT_BITS'(1);
					if (cnt_q == CNT_BITS'(DIV_STEPS - 1)) begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					state_q <= ST_COMMIT;
				end
				ST_COMMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			item_q <= pop_item;
		end
		if (commit) begin
			res_q <= res_n;
		end
		if (state_q == ST_EXEC) begin
			n_q   <= diff[63:0];
			rem_q <= '0;
		end else if (state_q == ST_DIV) begin
			n_q   <= {n_q[62:0], trial_ge};
			rem_q <= trial_ge ? trial_sub[15:0] : trial[15:0];
		end
		if (state_q == ST_PREP) begin
			// saturated quotient advances the baseline by size * (2^32 - 1)
			sat_q  <= |n_q[63:32];
			qs_q   <= (|n_q[63:32]) ? 32'hFFFF_FFFF : n_q[31:0];
			prod_q <= {16'd0, item_q.bytes_per_token, 32'd0} - {48'd0, item_q.bytes_per_token};
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.can_send    = res_q.can_send;
	assign rsp.can_probe   = res_q.can_probe;
	assign rsp.token_count = res_q.token_count;
	assign rsp.bucket_max  = res_q.bucket_max;
	assign rsp.sent_count  = res_q.sent_count;
	assign rsp.blocked     = res_q.blocked;
	assign rsp.refilled    = res_q.refilled;
	assign rsp.resumed     = res_q.resumed;

endmodule

// ===== rtl/ack_clocked_burst_pacer.sv =====
// Ack-clocked burst pacer. A request passes the front-end register, the two-entry queue and
// the back end before its result is registered; an acked event that runs the divider
// (nonzero size, no regression) also passes the one-bit-a-cycle divider and a prepare state.
// The back end takes a new event only once the last result is committed, while the queue
// keeps requests flowing. Reset (arst_n low, asynchronous): bucket, capacity, sent count,
// backpressure and ack baseline cleared; queue and result register emptied.
module ack_clocked_burst_pacer #(
	parameter int TOKEN_BITS = 16,
	parameter int SENT_BITS  = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	acbp_req_if.sink    req,
	acbp_rsp_if.source  rsp
);

	acbp_pkg::q_stat_t q_stat;
	acbp_pkg::item_t   push_item;
	acbp_pkg::item_t   pop_item;
	logic              push;
	logic              pop;

	acbp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.q_stat    (q_stat),
		.push      (push),
		.push_item (push_item)
	);

	acbp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.pop_item  (pop_item),
		.q_stat    (q_stat)
	);

	acbp_back #(
		.TOKEN_BITS (TOKEN_BITS),
		.SENT_BITS  (SENT_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_stat   (q_stat),
		.pop_item (pop_item),
		.pop      (pop),
		.rsp      (rsp)
	);

`ifndef SYNTHESIS
	a_resume_needs_refill: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.resumed |-> rsp.refilled)
		else $error("resume reported without a refill");

	a_refill_clears_block: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.refilled |-> !rsp.blocked)
		else $error("refill left backpressure set");

	a_tokens_within_cap: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && (TOKEN_BITS <= 16) |-> rsp.token_count <= rsp.bucket_max)
		else $error("token count above bucket capacity");
`endif

endmodule
